@@ hdl/uxcf_pkg.sv @@
// Package for the UTF-8 XML 1.0 character filter.
// Holds the queue entry type, code point limits and the XML character check.
// No dependencies.
package uxcf_pkg;

  localparam int BYTE_W  = 8;
  localparam int CP_W    = 21;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_SURR_LO  = 21'h00D7FF;
  localparam logic [CP_W-1:0] CP_SURR_HI  = 21'h00E000;
  localparam logic [CP_W-1:0] CP_BMP_MAX  = 21'h00FFFD;
  localparam logic [CP_W-1:0] CP_TAB      = 21'h000009;
  localparam logic [CP_W-1:0] CP_LF       = 21'h00000A;
  localparam logic [CP_W-1:0] CP_CR       = 21'h00000D;
  localparam logic [CP_W-1:0] CP_SPACE    = 21'h000020;

  localparam logic [2:0] LEN_1 = 3'd1;
  localparam logic [2:0] LEN_2 = 3'd2;
  localparam logic [2:0] LEN_3 = 3'd3;
  localparam logic [2:0] LEN_4 = 3'd4;

  // One finished character (or bare end marker) waiting for the back end.
  typedef struct packed {
    logic [3:0][BYTE_W-1:0] bytes;
    logic [2:0]             cnt;    // kept bytes, 0 for a bare end marker
    logic                   eos;
    logic                   err;
  } job_t;

  function automatic logic xml_allowed(input logic [2:0] len, input logic [CP_W-1:0] cp);
    logic ok;
    case (len)
      LEN_4:   ok = (cp <= CP_MAX);
      LEN_3:   ok = (cp <= CP_SURR_LO) || ((cp >= CP_SURR_HI) && (cp <= CP_BMP_MAX));
      LEN_2:   ok = 1'b1;
      default: ok = (cp == CP_TAB) || (cp == CP_LF) || (cp == CP_CR) || (cp >= CP_SPACE);
    endcase
    return ok;
  endfunction

endpackage

@@ hdl/uxcf_if.sv @@
// Valid/ready channel interfaces for the input bytes and the filtered words.
// Depends on uxcf_pkg.
interface uxcf_in_if;
  logic                       valid;
  logic                       ready;
  logic [uxcf_pkg::BYTE_W-1:0] in_byte;
  logic                       end_of_string;

  modport source(output valid, in_byte, end_of_string, input ready);
  modport sink(input valid, in_byte, end_of_string, output ready);
endinterface

interface uxcf_out_if;
  logic                       valid;
  logic                       ready;
  logic [uxcf_pkg::BYTE_W-1:0] out_byte;
  logic                       byte_valid;
  logic                       string_done;
  logic                       error_seen;
  logic                       run_last;

  modport source(output valid, out_byte, byte_valid, string_done, error_seen, run_last,
                 input ready);
  modport sink(input valid, out_byte, byte_valid, string_done, error_seen, run_last,
               output ready);
endinterface

@@ hdl/uxcf_front.sv @@
// Front end: takes one byte per cycle while the queue is not full, decodes UTF-8, checks the XML 1.0 range
// and pushes each kept character or end marker as a job. Depends on uxcf_pkg.
module uxcf_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [uxcf_pkg::BYTE_W-1:0] in_byte,
  input  logic                        in_eos,
  input  logic                        q_full,
  output logic                        push,
  output uxcf_pkg::job_t              push_job
);
  import uxcf_pkg::*;

  logic [CP_W-1:0]             acc_r, acc_nxt;
  logic [2:0]                  len_r, len_nxt;
  logic [1:0]                  rem_r, rem_nxt;
  logic                        err_r, err_nxt;
  logic [3:0][BYTE_W-1:0]      held_r, held_nxt;
  logic [2:0]                  emit;
  logic [1:0]                  pos;
  logic                        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    acc_nxt  = acc_r;
    len_nxt  = len_r;
    rem_nxt  = rem_r;
    err_nxt  = err_r;
    held_nxt = held_r;
    emit     = 3'd0;
    pos      = len_r[1:0] - rem_r;
    if (rem_r == 2'd0) begin
      held_nxt[0] = in_byte;
      if (in_byte[7:3] == 5'b11110) begin
        acc_nxt = {in_byte[2:0], 18'd0};
        len_nxt = LEN_4;
        rem_nxt = 2'd3;
      end else if (in_byte[7:4] == 4'b1110) begin
        acc_nxt = {5'd0, in_byte[3:0], 12'd0};
        len_nxt = LEN_3;
        rem_nxt = 2'd2;
      end else if (in_byte[7:5] == 3'b110) begin
        acc_nxt = {10'd0, in_byte[4:0], 6'd0};
        len_nxt = LEN_2;
        rem_nxt = 2'd1;
      end else if (!in_byte[7]) begin
        acc_nxt = {13'd0, in_byte};
        len_nxt = LEN_1;
        if (xml_allowed(LEN_1, acc_nxt)) begin
          emit = LEN_1;
        end
      end else begin
        err_nxt = 1'b1;   // stray continuation or 11111xxx lead
      end
    end else begin
      held_nxt[pos] = in_byte;
      case (rem_r)
        2'd3:    acc_nxt = acc_r | {3'd0, in_byte[5:0], 12'd0};
        2'd2:    acc_nxt = acc_r | {9'd0, in_byte[5:0], 6'd0};
        default: acc_nxt = acc_r | {15'd0, in_byte[5:0]};
      endcase
      rem_nxt = rem_r - 2'd1;
      if ((rem_nxt == 2'd0) && xml_allowed(len_r, acc_nxt)) begin
        emit = len_r;
      end
    end
    if (in_eos && (rem_nxt != 2'd0)) begin
      err_nxt = 1'b1;     // truncated at end of string
    end
  end

  assign push           = accept && ((emit != 3'd0) || in_eos);
  assign push_job.bytes = held_nxt;
  assign push_job.cnt   = emit;
  assign push_job.eos   = in_eos;
  assign push_job.err   = err_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      len_r <= '0;
      rem_r <= '0;
      err_r <= 1'b0;
    end else if (accept) begin
      if (in_eos) begin
        acc_r <= '0;
        len_r <= '0;
        rem_r <= '0;
        err_r <= 1'b0;
      end else begin
        acc_r <= acc_nxt;
        len_r <= len_nxt;
        rem_r <= rem_nxt;
        err_r <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_r <= held_nxt;
    end
  end

endmodule

@@ hdl/uxcf_queue.sv @@
// Short job queue between the decode front end and the output back end.
// Depends on uxcf_pkg.
module uxcf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  uxcf_pkg::job_t push_job,
  input  logic           pop,
  output uxcf_pkg::job_t head_job,
  output logic           empty,
  output logic           full
);
  import uxcf_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ hdl/uxcf_back.sv @@
// Back end: takes jobs from the queue and plays out one word per cycle while out_ready is high.
// Depends on uxcf_pkg.
module uxcf_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  uxcf_pkg::job_t              head_job,
  input  logic                        q_empty,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [uxcf_pkg::BYTE_W-1:0] out_byte,
  output logic                        byte_valid,
  output logic                        string_done,
  output logic                        error_seen,
  output logic                        run_last
);
  import uxcf_pkg::*;

  job_t       job_r;
  logic [1:0] idx_r;
  logic       busy_r;
  logic       last;

  assign last        = (job_r.cnt == 3'd0) || ({1'b0, idx_r} == (job_r.cnt - 3'd1));
  assign pop         = !q_empty && (!busy_r || (out_ready && last));
  assign out_valid   = busy_r;
  assign byte_valid  = (job_r.cnt != 3'd0);
  assign out_byte    = byte_valid ? job_r.bytes[idx_r] : '0;
  assign run_last    = last;
  assign string_done = job_r.eos && last;
  assign error_seen  = job_r.err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (pop) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (busy_r && out_ready) begin
      if (last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= head_job;
    end
  end

endmodule

@@ hdl/utf8_xml_char_filter_top.sv @@
// Top level of the UTF-8 XML 1.0 character filter.
// Depends on uxcf_pkg, uxcf_if, uxcf_front, uxcf_queue, uxcf_back.
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    in_byte[7:0], end_of_string
//   out_ch    out  valid/ready    out_byte[7:0], byte_valid, string_done,
//                                 error_seen, run_last
//
// One byte is taken per cycle while the 4-entry job queue has room.
// A kept character leaves as 1 to 4 words, one per cycle while out_ready is high,
// from the back end; its job is written into the queue, then loaded into the back end.
// Reset (rst_n low, synchronous) empties the queue and clears decode state.
// Output stalls back up into the queue; input stalls only when it is full.
module utf8_xml_char_filter_top (
  input logic      clk,
  input logic      rst_n,
  uxcf_in_if.sink  in_ch,
  uxcf_out_if.source out_ch
);
  import uxcf_pkg::*;

  job_t push_job, head_job;
  logic push, pop, q_empty, q_full;

  uxcf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.in_byte),
    .in_eos   (in_ch.end_of_string),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  uxcf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  uxcf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_job    (head_job),
    .q_empty     (q_empty),
    .pop         (pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_byte    (out_ch.out_byte),
    .byte_valid  (out_ch.byte_valid),
    .string_done (out_ch.string_done),
    .error_seen  (out_ch.error_seen),
    .run_last    (out_ch.run_last)
  );

endmodule

@@ hdl/uxcf_checker.sv @@
// Port-level checks for the character filter, bound to the top level.
// Depends on uxcf_pkg.
module uxcf_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [uxcf_pkg::BYTE_W-1:0] out_byte,
  input logic                        byte_valid,
  input logic                        string_done,
  input logic                        error_seen,
  input logic                        run_last
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_valid)
      && $stable(string_done) && $stable(error_seen) && $stable(run_last))
    else $error("output word changed while stalled");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && string_done |-> run_last)
    else $error("string_done without run_last");

  // bare end marker carries zero data and closes the string
  a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_valid |-> string_done && (out_byte == '0))
    else $error("malformed bare end marker");

  // words inside a run all carry data and never close the string
  a_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !run_last |-> byte_valid && !string_done)
    else $error("bad word inside a run");

endmodule

bind utf8_xml_char_filter_top uxcf_checker u_uxcf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .byte_valid  (out_ch.byte_valid),
  .string_done (out_ch.string_done),
  .error_seen  (out_ch.error_seen),
  .run_last    (out_ch.run_last)
);
